// ----- sv/mst_pkg.sv -----
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the multitouch slot tracker
// Event codes, register indexes, result kinds, controller states and the
// command and status records between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mst_pkg;

    localparam logic [15:0] TYPE_SYN  = 16'd0;
    localparam logic [15:0] TYPE_ABS  = 16'd3;
    localparam logic [15:0] CODE_REPORT = 16'h0000;
    localparam logic [15:0] CODE_SLOT = 16'h002f;
    localparam logic [15:0] CODE_TID  = 16'h0039;
    localparam logic [15:0] CODE_X    = 16'h0035;
    localparam logic [15:0] CODE_Y    = 16'h0036;
    localparam logic [15:0] CODE_PRES = 16'h003a;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET  = 3'd6;

    localparam logic [1:0] KIND_DOWN   = 2'd0;
    localparam logic [1:0] KIND_MOTION = 2'd1;
    localparam logic [1:0] KIND_UP     = 2'd2;

    localparam int DIV_W  = 44;   // |value * factor| < 2^44
    localparam int DVSR_W = 16;
    localparam int PROD_W = 46;

    localparam logic [10:0] PRES_ZERO = 11'd0;
    localparam logic [10:0] PRES_HALF = 11'd512;
    localparam logic [10:0] PRES_FULL = 11'd1024;
    localparam logic [12:0] PRES_SCALE = 13'd1024;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_SLOT,
        EV_TID_REL,
        EV_TID_CLAIM,
        EV_X,
        EV_Y,
        EV_PRES,
        EV_SYNC
    } ev_class_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TID_ACT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SYNC_RD,
        ST_SYNC_EV,
        ST_SYNC_END
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic set_slot;
        logic rd_en;
        logic rd_walk;
        logic claim;
        logic release_slot;
        logic emit_up;
        logic mul_go;
        logic div_start;
        logic wr_axis;
        logic wr_pres_direct;
        logic walk_clr;
        logic walk_inc;
        logic walk_emit;
        logic clr_moved;
    } cmd_t;

    typedef struct packed {
        ev_class_t ev;
        logic      slot_ok;
        logic      sel_mapped;
        logic      sel_down;
        logic      pres_direct;
        logic      walk_q;
        logic      walk_at_end;
        logic      div_done;
        logic      div_busy;
        logic      out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- sv/mst_event_if.sv -----
// ----------------------------------------------------------------------------
// mst_event_if: raw touch event channel
// Valid/ready channel carrying one (type, code, value) event per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mst_event_if;
    logic               valid;
    logic               ready;
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;

    modport source (output valid, output event_type, output event_code,
                    output event_value, input ready);
    modport sink   (input valid, input event_type, input event_code,
                    input event_value, output ready);
endinterface

`default_nettype wire

// ----- sv/mst_result_if.sv -----
// ----------------------------------------------------------------------------
// mst_result_if: finger result channel
// Valid/ready channel carrying one finger down/motion/up per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mst_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [30:0] finger_id;
    logic [11:0] x_pixel;
    logic [11:0] y_pixel;
    logic [10:0] pressure_level;
    logic        last_of_run;

    modport source (output valid, output event_kind, output finger_id,
                    output x_pixel, output y_pixel, output pressure_level,
                    output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input finger_id,
                    input x_pixel, input y_pixel, input pressure_level,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- sv/mst_div.sv -----
// ----------------------------------------------------------------------------
// mst_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [mst_pkg::DIV_W-1:0]  dividend,
    input  wire logic [mst_pkg::DVSR_W-1:0] divisor,
    output logic                            busy,
    output logic                            done,
    output logic [mst_pkg::DIV_W-1:0]       quotient
);
    localparam int CNT_W = $clog2(mst_pkg::DIV_W + 1);

    logic [mst_pkg::DIV_W-1:0]  quo_reg, quo_next;
    logic [mst_pkg::DVSR_W:0]   rem_reg, rem_next;
    logic [mst_pkg::DVSR_W-1:0] dvsr_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg, done_reg;
    logic [mst_pkg::DVSR_W:0]   trial;
    logic                       fits;

    always_comb
    begin
        trial    = {rem_reg[mst_pkg::DVSR_W-1:0], quo_reg[mst_pkg::DIV_W-1]};
        fits     = trial >= {1'b0, dvsr_reg};
        rem_next = fits ? trial - {1'b0, dvsr_reg} : trial;
        quo_next = {quo_reg[mst_pkg::DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(mst_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

`default_nettype wire

// ----- sv/mst_ctrl.sv -----
// ----------------------------------------------------------------------------
// mst_ctrl: sequencer of the slot tracker
// Accepts one event, steps the datapath through it, then returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             evt_valid,
    output logic                  evt_ready,
    input  wire mst_pkg::status_t status,
    output mst_pkg::cmd_t         cmd
);
    mst_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mst_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        evt_ready  = 1'b0;
        case (state_reg)
            mst_pkg::ST_IDLE:
            begin
                evt_ready = 1'b1;
                if (evt_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = mst_pkg::ST_DECODE;
                end
            end
            mst_pkg::ST_DECODE:
            begin
                state_next = mst_pkg::ST_IDLE;
                case (status.ev)
                    mst_pkg::EV_SLOT: cmd.set_slot = 1'b1;
                    mst_pkg::EV_SYNC:
                    begin
                        cmd.walk_clr = 1'b1;
                        state_next   = mst_pkg::ST_SYNC_RD;
                    end
                    mst_pkg::EV_TID_REL, mst_pkg::EV_TID_CLAIM:
                    begin
                        if (status.slot_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = mst_pkg::ST_TID_ACT;
                        end
                    end
                    mst_pkg::EV_X, mst_pkg::EV_Y, mst_pkg::EV_PRES:
                    begin
                        if (status.slot_ok && status.sel_mapped)
                        begin
                            if (status.ev == mst_pkg::EV_PRES && status.pres_direct)
                                cmd.wr_pres_direct = 1'b1;
                            else
                            begin
                                cmd.mul_go = 1'b1;
                                state_next = mst_pkg::ST_DIV_START;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            mst_pkg::ST_TID_ACT:
            begin
                state_next = mst_pkg::ST_IDLE;
                if (status.ev == mst_pkg::EV_TID_CLAIM)
                    cmd.claim = 1'b1;
                else if (status.sel_mapped)
                begin
                    if (status.sel_down)
                    begin
                        if (status.out_free)
                        begin
                            cmd.emit_up      = 1'b1;
                            cmd.release_slot = 1'b1;
                        end
                        else
                            state_next = mst_pkg::ST_TID_ACT;
                    end
                    else
                        cmd.release_slot = 1'b1;
                end
            end
            mst_pkg::ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = mst_pkg::ST_DIV_WAIT;
            end
            mst_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.wr_axis = 1'b1;
                    state_next  = mst_pkg::ST_IDLE;
                end
            end
            mst_pkg::ST_SYNC_RD:
            begin
                if (status.walk_q)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_walk = 1'b1;
                    state_next  = mst_pkg::ST_SYNC_EV;
                end
                else if (status.walk_at_end)
                    state_next = mst_pkg::ST_SYNC_END;
                else
                    cmd.walk_inc = 1'b1;
            end
            mst_pkg::ST_SYNC_EV:
            begin
                if (status.out_free)
                begin
                    cmd.walk_emit = 1'b1;
                    if (status.walk_at_end)
                        state_next = mst_pkg::ST_SYNC_END;
                    else
                    begin
                        cmd.walk_inc = 1'b1;
                        state_next   = mst_pkg::ST_SYNC_RD;
                    end
                end
            end
            mst_pkg::ST_SYNC_END:
            begin
                cmd.clr_moved = 1'b1;
                state_next    = mst_pkg::ST_IDLE;
            end
            default: state_next = mst_pkg::ST_IDLE;
        endcase
    end
endmodule

`default_nettype wire

// ----- sv/mst_datapath.sv -----
// ----------------------------------------------------------------------------
// mst_datapath: slot table, scaling and result register
// Holds configuration, slot flags, per-slot memories, the scaling multiplier
// and divider, calibration and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_datapath #(
    parameter int SLOTS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [mst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mst_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [15:0]                    in_type,
    input  wire logic [15:0]                    in_code,
    input  wire logic [31:0]                    in_value,
    input  wire mst_pkg::cmd_t                  cmd,
    output mst_pkg::status_t                    status,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [1:0]                          out_kind,
    output logic [30:0]                         out_id,
    output logic [11:0]                         out_x,
    output logic [11:0]                         out_y,
    output logic [10:0]                         out_pres,
    output logic                                out_last
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // configuration
    logic [12:0]        scr_w_reg, scr_h_reg;
    logic [15:0]        x_max_reg, y_max_reg, p_max_reg;
    logic signed [13:0] x_off_reg, y_off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= 13'd1024;
            scr_h_reg <= 13'd768;
            x_max_reg <= 16'd4095;
            y_max_reg <= 16'd4095;
            p_max_reg <= 16'd255;
            x_off_reg <= '0;
            y_off_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mst_pkg::CFG_SCREEN_W: scr_w_reg <= cfg_data[12:0];
                mst_pkg::CFG_SCREEN_H: scr_h_reg <= cfg_data[12:0];
                mst_pkg::CFG_X_MAX:    x_max_reg <= cfg_data;
                mst_pkg::CFG_Y_MAX:    y_max_reg <= cfg_data;
                mst_pkg::CFG_PRES_MAX: p_max_reg <= cfg_data;
                mst_pkg::CFG_X_OFFSET: x_off_reg <= $signed(cfg_data[13:0]);
                mst_pkg::CFG_Y_OFFSET: y_off_reg <= $signed(cfg_data[13:0]);
                default: ;
            endcase
        end
    end

    // latched event and slot select
    logic [15:0]        type_reg, code_reg;
    logic signed [31:0] val_reg;
    logic [31:0]        sel_reg;
    logic [IW-1:0]      sel_idx;
    logic [IW-1:0]      walk_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            type_reg <= in_type;
            code_reg <= in_code;
            val_reg  <= $signed(in_value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg  <= '0;
            walk_reg <= '0;
        end
        else
        begin
            if (cmd.set_slot)
                sel_reg <= val_reg;
            if (cmd.walk_clr)
                walk_reg <= '0;
            else if (cmd.walk_inc)
                walk_reg <= walk_reg + 1'b1;
        end
    end

    assign sel_idx = sel_reg[IW-1:0];

    mst_pkg::ev_class_t ev;
    always_comb
    begin
        ev = mst_pkg::EV_NONE;
        if (type_reg == mst_pkg::TYPE_ABS)
        begin
            case (code_reg)
                mst_pkg::CODE_SLOT: ev = mst_pkg::EV_SLOT;
                mst_pkg::CODE_TID:
                    ev = (val_reg == -32'sd1) ? mst_pkg::EV_TID_REL
                                              : mst_pkg::EV_TID_CLAIM;
                mst_pkg::CODE_X:    ev = mst_pkg::EV_X;
                mst_pkg::CODE_Y:    ev = mst_pkg::EV_Y;
                mst_pkg::CODE_PRES: ev = mst_pkg::EV_PRES;
                default:            ev = mst_pkg::EV_NONE;
            endcase
        end
        else if (type_reg == mst_pkg::TYPE_SYN && code_reg == mst_pkg::CODE_REPORT)
            ev = mst_pkg::EV_SYNC;
    end

    // slot flags
    logic [SLOTS-1:0] mapped_reg, down_reg, has_pos_reg, moved_reg;
    logic [SLOTS-1:0] qual;
    logic             more_after;
    logic [31:0]      rd_tid;

    assign qual = mapped_reg & ((~down_reg & has_pos_reg) | (down_reg & moved_reg));

    always_comb
    begin
        more_after = 1'b0;
        for (int j = 0; j < SLOTS; j++)
            if (IW'(j) > walk_reg && qual[j])
                more_after = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapped_reg  <= '0;
            down_reg    <= '0;
            has_pos_reg <= '0;
            moved_reg   <= '0;
        end
        else
        begin
            if (cmd.claim)
            begin
                if (!mapped_reg[sel_idx] || rd_tid != val_reg)
                    down_reg[sel_idx] <= 1'b0;
                mapped_reg[sel_idx]  <= 1'b1;
                has_pos_reg[sel_idx] <= 1'b0;
                moved_reg[sel_idx]   <= 1'b0;
            end
            if (cmd.release_slot)
            begin
                mapped_reg[sel_idx]  <= 1'b0;
                down_reg[sel_idx]    <= 1'b0;
                has_pos_reg[sel_idx] <= 1'b0;
                moved_reg[sel_idx]   <= 1'b0;
            end
            if (cmd.wr_axis || cmd.wr_pres_direct)
            begin
                moved_reg[sel_idx] <= 1'b1;
                if (ev == mst_pkg::EV_Y)
                    has_pos_reg[sel_idx] <= 1'b1;
            end
            if (cmd.walk_emit)
                down_reg[walk_reg] <= 1'b1;
            if (cmd.clr_moved)
                moved_reg <= '0;
        end
    end

    // per-slot memories, registered read
    logic [31:0]        tid_mem [SLOTS];
    logic signed [31:0] sx_mem  [SLOTS];
    logic signed [31:0] sy_mem  [SLOTS];
    logic [10:0]        sp_mem  [SLOTS];
    logic [11:0]        rx_mem  [SLOTS];
    logic [11:0]        ry_mem  [SLOTS];
    logic [10:0]        rp_mem  [SLOTS];

    logic [IW-1:0]      rd_addr;
    logic signed [31:0] rd_sx, rd_sy;
    logic [10:0]        rd_sp, rd_rp;
    logic [11:0]        rd_rx, rd_ry;

    assign rd_addr = cmd.rd_walk ? walk_reg : sel_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_tid <= tid_mem[rd_addr];
            rd_sx  <= sx_mem[rd_addr];
            rd_sy  <= sy_mem[rd_addr];
            rd_sp  <= sp_mem[rd_addr];
            rd_rx  <= rx_mem[rd_addr];
            rd_ry  <= ry_mem[rd_addr];
            rd_rp  <= rp_mem[rd_addr];
        end
    end

    // scaling: product register, then divider
    logic [12:0]                 factor;
    logic [15:0]                 dvsr_raw;
    logic [mst_pkg::DVSR_W-1:0]  dvsr;
    logic signed [mst_pkg::PROD_W-1:0] prod_reg;
    logic [mst_pkg::PROD_W-1:0]  mag_full;
    logic [mst_pkg::DIV_W-1:0]   quo;
    logic                        div_busy, div_done;
    logic signed [31:0]          axis_res;
    logic                        pres_direct;
    logic [10:0]                 pres_direct_val;

    always_comb
    begin
        case (ev)
            mst_pkg::EV_X:
            begin
                factor   = scr_w_reg;
                dvsr_raw = x_max_reg;
            end
            mst_pkg::EV_Y:
            begin
                factor   = scr_h_reg;
                dvsr_raw = y_max_reg;
            end
            default:
            begin
                factor   = mst_pkg::PRES_SCALE;
                dvsr_raw = p_max_reg;
            end
        endcase
        dvsr = (dvsr_raw == '0) ? 16'd1 : dvsr_raw;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
            prod_reg <= mst_pkg::PROD_W'(val_reg) *
                        mst_pkg::PROD_W'($signed({1'b0, factor}));
    end

    assign mag_full = prod_reg[mst_pkg::PROD_W-1] ? mst_pkg::PROD_W'(-prod_reg)
                                                   : prod_reg;

    mst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mag_full[mst_pkg::DIV_W-1:0]),
        .divisor  (dvsr),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    // truncating quotient, saturated to 32-bit signed
    always_comb
    begin
        if (prod_reg[mst_pkg::PROD_W-1])
        begin
            if (quo > 44'h0_8000_0000)
                axis_res = 32'sh8000_0000;
            else
                axis_res = $signed(~quo[31:0] + 32'd1);
        end
        else if (quo > 44'h0_7fff_ffff)
            axis_res = 32'sh7fff_ffff;
        else
            axis_res = $signed(quo[31:0]);
    end

    assign pres_direct = (p_max_reg == '0) || (val_reg <= 32'sd0) ||
                         ($signed({1'b0, val_reg}) >= $signed({17'b0, p_max_reg}));
    assign pres_direct_val = (p_max_reg == '0) ? mst_pkg::PRES_HALF :
                             (val_reg <= 32'sd0) ? mst_pkg::PRES_ZERO :
                             mst_pkg::PRES_FULL;

    // calibration: add offset, clamp to [0, min(scr-1, 4095)]
    function automatic logic [11:0] calib(input logic signed [31:0] v,
                                          input logic signed [13:0] off,
                                          input logic [12:0] scr);
        logic signed [33:0] p;
        logic signed [33:0] hi;
        begin
            p  = 34'(v) + 34'(off);
            hi = $signed({21'b0, scr}) - 34'sd1;
            if (p > hi)
                p = hi;
            if (p > 34'sd4095)
                p = 34'sd4095;
            if (p < 34'sd0)
                p = 34'sd0;
            return p[11:0];
        end
    endfunction

    logic [11:0] cal_x, cal_y;
    assign cal_x = calib(rd_sx, x_off_reg, scr_w_reg);
    assign cal_y = calib(rd_sy, y_off_reg, scr_h_reg);

    // memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.claim)
            tid_mem[sel_idx] <= val_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.claim)
            sx_mem[sel_idx] <= '0;
        else if (cmd.wr_axis && ev == mst_pkg::EV_X)
            sx_mem[sel_idx] <= axis_res;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.claim)
            sy_mem[sel_idx] <= '0;
        else if (cmd.wr_axis && ev == mst_pkg::EV_Y)
            sy_mem[sel_idx] <= axis_res;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.claim)
            sp_mem[sel_idx] <= mst_pkg::PRES_HALF;
        else if (cmd.wr_pres_direct)
            sp_mem[sel_idx] <= pres_direct_val;
        else if (cmd.wr_axis && ev == mst_pkg::EV_PRES)
            sp_mem[sel_idx] <= quo[10:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_emit)
        begin
            rx_mem[walk_reg] <= cal_x;
            ry_mem[walk_reg] <= cal_y;
            rp_mem[walk_reg] <= rd_sp;
        end
    end

    // output register
    logic        ov_reg;
    logic [1:0]  ok_reg;
    logic [30:0] oid_reg;
    logic [11:0] ox_reg, oy_reg;
    logic [10:0] op_reg;
    logic        ol_reg;
    logic        out_free;

    assign out_free = !ov_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.emit_up || cmd.walk_emit)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_up)
        begin
            ok_reg  <= mst_pkg::KIND_UP;
            oid_reg <= rd_tid[30:0];
            ox_reg  <= rd_rx;
            oy_reg  <= rd_ry;
            op_reg  <= rd_rp;
            ol_reg  <= 1'b1;
        end
        else if (cmd.walk_emit)
        begin
            ok_reg  <= down_reg[walk_reg] ? mst_pkg::KIND_MOTION : mst_pkg::KIND_DOWN;
            oid_reg <= rd_tid[30:0];
            ox_reg  <= cal_x;
            oy_reg  <= cal_y;
            op_reg  <= rd_sp;
            ol_reg  <= !more_after;
        end
    end

    assign out_valid = ov_reg;
    assign out_kind  = ok_reg;
    assign out_id    = oid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_pres  = op_reg;
    assign out_last  = ol_reg;

    always_comb
    begin
        status             = '0;
        status.ev          = ev;
        status.slot_ok     = sel_reg < 32'(SLOTS);
        status.sel_mapped  = mapped_reg[sel_idx];
        status.sel_down    = down_reg[sel_idx];
        status.pres_direct = pres_direct;
        status.walk_q      = qual[walk_reg];
        status.walk_at_end = walk_reg == IW'(SLOTS - 1);
        status.div_done    = div_done;
        status.div_busy    = div_busy;
        status.out_free    = out_free;
    end
endmodule

`default_nettype wire

// ----- sv/multitouch_slot_tracker_core.sv -----
// Sequence: slot and ignored events pass decode only; a tracking id adds the slot
// action state; x, y or pressure go through the product register and bit-serial
// divider unless pressure is fixed or saturates; a sync report walks all slots.
// One event at a time; the divider, slot walk or a waiting result sets the pace.
// Reset (rst_n, async low): flags, slot select and config clear at once;
// no memory sweep is needed, per-slot values are written before being read.
// ----------------------------------------------------------------------------
// multitouch_slot_tracker_core: multitouch slot tracker top level
// Decodes raw multitouch events into finger down, motion and up transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module multitouch_slot_tracker_core #(
    parameter int SLOTS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    mst_event_if.sink                           evt,
    mst_result_if.source                        res,
    input  wire logic                           cfg_we,
    input  wire logic [mst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mst_pkg::CFG_DATA_W-1:0] cfg_data
);
    mst_pkg::cmd_t    cmd;
    mst_pkg::status_t status;
    logic             evt_ready;

    // Controller: one event in flight; ready only while idle.
    mst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (evt_ready),
        .status    (status),
        .cmd       (cmd)
    );

    assign evt.ready = evt_ready;

    // Datapath: slot table, scaling divider, calibration and the output
    // register that decouples a waiting result transfer from the next event.
    mst_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_type   (evt.event_type),
        .in_code   (evt.event_code),
        .in_value  (evt.event_value),
        .cmd       (cmd),
        .status    (status),
        .out_ready (res.ready),
        .out_valid (res.valid),
        .out_kind  (res.event_kind),
        .out_id    (res.finger_id),
        .out_x     (res.x_pixel),
        .out_y     (res.y_pixel),
        .out_pres  (res.pressure_level),
        .out_last  (res.last_of_run)
    );

    // no new event while a divide is running
    a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_busy |-> !evt.ready)
        else $error("event accepted during divide");

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_up || cmd.walk_emit) && res.valid |-> res.ready)
        else $error("result register overwritten");

    // the walk emits only for a slot that qualifies
    a_walk_qual: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_emit |-> status.walk_q)
        else $error("walk emitted for idle slot");
endmodule

`default_nettype wire

// ----- verif/multitouch_slot_tracker_core_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multitouch_slot_tracker_core_chk: finger result predictor and comparator
// Watches the event and result channels and the config port. Keeps its own
// copy of the slot table, queues the finger results each accepted event
// should cause and compares every result transfer against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module multitouch_slot_tracker_core_chk #(
    parameter int SLOTS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    mst_event_if.sink                           evt,
    mst_result_if.sink                          res,
    input  wire logic                           cfg_we,
    input  wire logic [mst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mst_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                  fail_count,
    output int                                  pending
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] id;
        logic [11:0] x;
        logic [11:0] y;
        logic [10:0] pres;
        logic        last;
    } finger_t;

    finger_t finger_q[$];

    logic [12:0] scr_w, scr_h;
    logic [15:0] xmax, ymax, pmax;
    logic signed [13:0] xoff, yoff;

    logic [31:0] sel;
    logic        mapped [SLOTS];
    logic [31:0] tid [SLOTS];
    logic signed [31:0] sx [SLOTS];
    logic signed [31:0] sy [SLOTS];
    logic [10:0] sp [SLOTS];
    logic        has_pos [SLOTS];
    logic        moved [SLOTS];
    logic        down [SLOTS];
    logic [11:0] rx [SLOTS];
    logic [11:0] ry [SLOTS];
    logic [10:0] rp [SLOTS];

    function automatic logic signed [31:0] scale_coord(longint v, longint scr, longint mx);
        longint d, q;
        d = (mx == 0) ? 1 : mx;
        q = v * scr / d;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic logic [11:0] to_screen(logic signed [31:0] v,
                                              logic signed [13:0] off, longint scr);
        longint p;
        p = longint'(v) + longint'(off);
        if (p > scr - 1) p = scr - 1;
        if (p > 4095) p = 4095;
        if (p < 0) p = 0;
        return p[11:0];
    endfunction

    function automatic logic [10:0] pres_fraction(longint v);
        if (pmax == 0) return mst_pkg::PRES_HALF;
        if (v <= 0) return mst_pkg::PRES_ZERO;
        if (v >= longint'(pmax)) return mst_pkg::PRES_FULL;
        return 11'((v * 1024) / longint'(pmax));
    endfunction

    task automatic predict_event(logic [15:0] ty, logic [15:0] cd, logic [31:0] raw);
        finger_t f;
        finger_t run[$];
        int      s;
        longint  v;
        v = longint'(signed'(raw));
        if (ty == mst_pkg::TYPE_ABS) begin
            if (cd == mst_pkg::CODE_SLOT) begin
                sel = raw;
            end else if (sel < SLOTS) begin
                s = sel;
                if (cd == mst_pkg::CODE_TID) begin
                    if (v == -1) begin
                        if (mapped[s]) begin
                            if (down[s]) begin
                                f = '{mst_pkg::KIND_UP, tid[s][30:0], rx[s], ry[s],
                                      rp[s], 1'b0};
                                run.push_back(f);
                            end
                            mapped[s] = 0; down[s] = 0; has_pos[s] = 0; moved[s] = 0;
                        end
                    end else begin
                        if (!mapped[s] || tid[s] != raw) down[s] = 0;
                        mapped[s] = 1; tid[s] = raw;
                        sx[s] = 0; sy[s] = 0; sp[s] = mst_pkg::PRES_HALF;
                        has_pos[s] = 0; moved[s] = 0;
                    end
                end else if (mapped[s]) begin
                    if (cd == mst_pkg::CODE_X) begin
                        sx[s] = scale_coord(v, scr_w, xmax);
                        moved[s] = 1;
                    end else if (cd == mst_pkg::CODE_Y) begin
                        sy[s] = scale_coord(v, scr_h, ymax);
                        moved[s] = 1; has_pos[s] = 1;
                    end else if (cd == mst_pkg::CODE_PRES) begin
                        sp[s] = pres_fraction(v);
                        moved[s] = 1;
                    end
                end
            end
        end else if (ty == mst_pkg::TYPE_SYN && cd == mst_pkg::CODE_REPORT) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (mapped[i] && (has_pos[i] && !down[i] || down[i] && moved[i])) begin
                    f.kind = down[i] ? mst_pkg::KIND_MOTION : mst_pkg::KIND_DOWN;
                    down[i] = 1;
                    rx[i] = to_screen(sx[i], xoff, scr_w);
                    ry[i] = to_screen(sy[i], yoff, scr_h);
                    rp[i] = sp[i];
                    f = '{f.kind, tid[i][30:0], rx[i], ry[i], rp[i], 1'b0};
                    run.push_back(f);
                end
            end
            for (int i = 0; i < SLOTS; i++) moved[i] = 0;
        end
        if (run.size() > 0) run[run.size()-1].last = 1;
        foreach (run[k]) finger_q.push_back(run[k]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        finger_t got, exp_f;
        if (!rst_n) begin
            scr_w = 1024; scr_h = 768; xmax = 4095; ymax = 4095; pmax = 255;
            xoff = 0; yoff = 0; sel = 0;
            for (int i = 0; i < SLOTS; i++) begin
                mapped[i] = 0; has_pos[i] = 0; moved[i] = 0; down[i] = 0;
            end
            finger_q.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    mst_pkg::CFG_SCREEN_W: scr_w = cfg_data[12:0];
                    mst_pkg::CFG_SCREEN_H: scr_h = cfg_data[12:0];
                    mst_pkg::CFG_X_MAX:    xmax = cfg_data;
                    mst_pkg::CFG_Y_MAX:    ymax = cfg_data;
                    mst_pkg::CFG_PRES_MAX: pmax = cfg_data;
                    mst_pkg::CFG_X_OFFSET: xoff = cfg_data[13:0];
                    mst_pkg::CFG_Y_OFFSET: yoff = cfg_data[13:0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                got = '{res.event_kind, res.finger_id, res.x_pixel, res.y_pixel,
                        res.pressure_level, res.last_of_run};
                if (finger_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    fail_count++;
                end else begin
                    exp_f = finger_q.pop_front();
                    if (got !== exp_f) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_f, got);
                        fail_count++;
                    end
                end
            end
            if (evt.valid && evt.ready)
                predict_event(evt.event_type, evt.event_code, evt.event_value);
            pending = finger_q.size();
        end
    end

endmodule

`default_nettype wire

// ----- verif/multitouch_slot_tracker_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multitouch_slot_tracker_core_tb: top of the slot tracker testbench
// Drives directed and random touch event streams under several register
// settings with random idling and one long output hold-off; the checker
// module predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module multitouch_slot_tracker_core_tb;

    localparam int SLOTS = 16;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [mst_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mst_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int   fail_count, pending;

    // Random idling is switched off during a calm stretch.
    bit   calm = 0;
    // Receiver hold-off request, served in the ready process.
    int   hold_cycles = 0;

    mst_event_if  evt ();
    mst_result_if res ();

    multitouch_slot_tracker_core #(.SLOTS(SLOTS)) DUT (
        .clk(clk), .rst_n(rst_n), .evt(evt), .res(res),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    multitouch_slot_tracker_core_chk #(.SLOTS(SLOTS)) u_chk (
        .clk(clk), .rst_n(rst_n), .evt(evt), .res(res),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    initial
    begin
        evt.valid = 0;
        evt.event_type = '0;
        evt.event_code = '0;
        evt.event_value = '0;
    end

    // Result side: ready drops ~16% of cycles, or for a long hold-off.
    initial
    begin
        res.ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res.ready <= 0;
                hold_cycles = hold_cycles - 1;
            end
            else
                res.ready <= calm || ($urandom_range(99) >= 16);
        end
    end

    // One event transfer; valid stays high between back-to-back events.
    task automatic send_event(logic [15:0] ty, logic [15:0] cd, logic [31:0] v);
        while (!calm && $urandom_range(99) < 16)
        begin
            evt.valid <= 0;
            @(negedge clk);
        end
        evt.valid <= 1;
        evt.event_type <= ty;
        evt.event_code <= cd;
        evt.event_value <= v;
        @(posedge clk);
        while (!evt.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_sender();
        evt.valid <= 0;
        @(negedge clk);
    endtask

    // Wait out every expected result plus the longest divide, then write.
    task automatic drain();
        idle_sender();
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    // One register write; the enable is dropped by the caller after the last.
    task automatic write_reg(logic [mst_pkg::CFG_IDX_W-1:0] idx,
                             logic [mst_pkg::CFG_DATA_W-1:0] d);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge clk);
    endtask

    task automatic set_regs(int w, int h, int xm, int ym, int pm, int xo, int yo);
        write_reg(mst_pkg::CFG_SCREEN_W, 16'(w));
        write_reg(mst_pkg::CFG_SCREEN_H, 16'(h));
        write_reg(mst_pkg::CFG_X_MAX, 16'(xm));
        write_reg(mst_pkg::CFG_Y_MAX, 16'(ym));
        write_reg(mst_pkg::CFG_PRES_MAX, 16'(pm));
        write_reg(mst_pkg::CFG_X_OFFSET, 16'(xo));
        write_reg(mst_pkg::CFG_Y_OFFSET, 16'(yo));
        cfg_we <= 0;
    endtask

    task automatic sync();
        send_event(mst_pkg::TYPE_SYN, mst_pkg::CODE_REPORT, 32'd0);
    endtask

    // Coordinates mostly near the sensor range, sometimes anywhere.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return $urandom;
            1: return -$urandom_range(5000);
            default: return $urandom_range(70000);
        endcase
    endfunction

    // A touch frame: one to four slot updates, at times a random event, and a sync.
    task automatic touch_frame();
        int n;
        int s;
        n = $urandom_range(4, 1);
        for (int k = 0; k < n; k++)
        begin
            s = ($urandom_range(19) == 0) ? $urandom_range(40, 16) : $urandom_range(SLOTS - 1);
            send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, s);
            case ($urandom_range(9))
                0: send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TID, -1);
                1: send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TID, $urandom);
                2: send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TID, $urandom_range(7));
                default: ;
            endcase
            if ($urandom_range(3) != 0)
                send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_X, rand_coord());
            if ($urandom_range(3) != 0)
                send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_Y, rand_coord());
            if ($urandom_range(2) == 0)
                send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_PRES,
                           ($urandom_range(4) == 0) ? $urandom : $urandom_range(300));
        end
        if ($urandom_range(9) == 0)
            send_event(16'($urandom), 16'($urandom), $urandom);
        sync();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: defaults first, claim, position, pressure extremes.
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, 0);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TID, 32'h7fff_ffff);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_X, 32'h7fff_ffff);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_Y, 32'h8000_0000);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_PRES, 1000);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, SLOTS - 1);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TID, -5);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_Y, 2000);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_PRES, -3);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, 3);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_X, 100);     // unmapped slot
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TID, -1);    // release of unmapped slot
        sync();
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, 0);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_PRES, 100);
        sync();                                                   // motion
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, 32'hffff_ffff); // out of range
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TID, 9);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, SLOTS - 1);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TID, -5);    // same id keeps down
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, 0);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TID, 77);    // new id drops old
        send_event(mst_pkg::TYPE_SYN, 16'hffff, 0);
        send_event(16'hffff, mst_pkg::CODE_X, 0);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, SLOTS - 1);
        send_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TID, -1);    // finger up
        sync();
        drain();

        // Zero maxima and zero screen, pressure fixed at half.
        set_regs(0, 0, 0, 0, 0, -4096, 4096);
        for (int k = 0; k < 4; k++) touch_frame();
        drain();
        set_regs(4096, 4096, 65535, 65535, 65535, 4096, -4096);
        for (int k = 0; k < 5; k++) touch_frame();
        drain();
        set_regs(1, 1, 1, 1, 1, 0, 0);
        for (int k = 0; k < 3; k++) touch_frame();

        // Long hold-off while frames keep coming, so the block backs up.
        hold_cycles = 400;
        for (int k = 0; k < 4; k++) touch_frame();
        drain();

        // Calm stretch, then random settings.
        calm = 1;
        set_regs(800, 600, 4095, 4095, 255, 10, -10);
        for (int k = 0; k < 5; k++) touch_frame();
        calm = 0;
        drain();
        for (int ph = 0; ph < 3; ph++)
        begin
            set_regs($urandom_range(4096, 1), $urandom_range(4096, 1),
                     $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                     $urandom_range(8192) - 4096, $urandom_range(8192) - 4096);
            for (int k = 0; k < 4; k++) touch_frame();
            drain();
        end

        idle_sender();
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
